[hdl/ctc_pkg.sv]
// package for the canonical tuple type classifier
// shared types, field widths, kind codes and fsm states; no dependencies
package ctc_pkg;

  // field widths
  localparam int unsigned TYPE_W  = 7;
  localparam int unsigned ATOM_W  = 16;
  localparam int unsigned INDEX_W = 9;

  // stream widths
  localparam int unsigned S_DATA_W = 96;
  localparam int unsigned S_USER_W = 3;
  localparam int unsigned M_DATA_W = 80;
  localparam int unsigned M_USER_W = 2;

  // number of per-kind tables and default table depth
  localparam int unsigned KIND_COUNT      = 5;
  localparam int unsigned TABLE_DEPTH_DEF = 512;

  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // term kinds
  typedef enum logic [2:0] {
    KIND_BOND        = 3'd0,
    KIND_ANGLE       = 3'd1,
    KIND_DIHEDRAL    = 3'd2,
    KIND_OOP         = 3'd3,
    KIND_ANGLE_ANGLE = 3'd4,
    KIND_CLEAR       = 3'd5
  } ctc_kind_e;

  // four atom types, member a in the lowest bits
  typedef struct packed {
    logic [TYPE_W-1:0] d;
    logic [TYPE_W-1:0] c;
    logic [TYPE_W-1:0] b;
    logic [TYPE_W-1:0] a;
  } ctc_tuple_t;

  // four atom indices, member a in the lowest bits
  typedef struct packed {
    logic [ATOM_W-1:0] d;
    logic [ATOM_W-1:0] c;
    logic [ATOM_W-1:0] b;
    logic [ATOM_W-1:0] a;
  } ctc_atoms_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0] kind;
    ctc_tuple_t tuple;
    ctc_atoms_t atoms;
  } ctc_item_t;

  // result item
  typedef struct packed {
    logic [INDEX_W-1:0] type_index;
    ctc_atoms_t         ordered;
    logic               new_entry;
    logic               overflow;
  } ctc_result_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESP
  } ctc_state_e;

endpackage

[hdl/ctc_front.sv]
// front end: accepts input transfers and puts each tuple into canonical order
// depends on ctc_pkg; output is one registered item toward the queue
module ctc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [ctc_pkg::S_DATA_W-1:0]  s_data_i,
  input  logic [ctc_pkg::S_USER_W-1:0]  s_user_i,
  output logic                          item_valid_o,
  input  logic                          item_ready_i,
  output ctc_pkg::ctc_item_t            item_o
);
  import ctc_pkg::*;

  logic [TYPE_W-1:0] t [4];
  logic [ATOM_W-1:0] m [4];
  logic [TYPE_W-1:0] tt;
  logic [ATOM_W-1:0] tm;
  ctc_tuple_t        in_tuple;
  ctc_atoms_t        in_atoms;
  ctc_item_t         item_d, item_q;
  logic              vld_d, vld_q;
  logic              take;

  assign in_tuple = s_data_i[4*TYPE_W-1:0];
  assign in_atoms = s_data_i[4*TYPE_W+4*ATOM_W-1:4*TYPE_W];

  // canonical reordering of types, indices follow
  always_comb begin
    t[0] = in_tuple.a;
    t[1] = in_tuple.b;
    t[2] = in_tuple.c;
    t[3] = in_tuple.d;
    m[0] = in_atoms.a;
    m[1] = in_atoms.b;
    m[2] = in_atoms.c;
    m[3] = in_atoms.d;
    tt   = '0;
    tm   = '0;
    case (s_user_i)
      KIND_BOND: begin
        t[2] = '0;
        t[3] = '0;
        m[2] = '0;
        m[3] = '0;
        if (t[1] < t[0]) begin
          tt = t[0]; t[0] = t[1]; t[1] = tt;
          tm = m[0]; m[0] = m[1]; m[1] = tm;
        end
      end
      KIND_ANGLE: begin
        t[3] = '0;
        m[3] = '0;
        if (t[2] < t[0]) begin
          tt = t[0]; t[0] = t[2]; t[2] = tt;
          tm = m[0]; m[0] = m[2]; m[2] = tm;
        end
      end
      KIND_DIHEDRAL: begin
        // reverse the chain when the inner pair, then the outer pair, says so
        if (t[2] < t[1] || (t[1] == t[2] && t[3] < t[0])) begin
          tt = t[0]; t[0] = t[3]; t[3] = tt;
          tm = m[0]; m[0] = m[3]; m[3] = tm;
          tt = t[1]; t[1] = t[2]; t[2] = tt;
          tm = m[1]; m[1] = m[2]; m[2] = tm;
        end
      end
      KIND_OOP, KIND_ANGLE_ANGLE: begin
        // exchange sort of a, c, d around the fixed centre b
        if (t[2] < t[0]) begin
          tt = t[0]; t[0] = t[2]; t[2] = tt;
          tm = m[0]; m[0] = m[2]; m[2] = tm;
        end
        if (t[3] < t[0]) begin
          tt = t[0]; t[0] = t[3]; t[3] = tt;
          tm = m[0]; m[0] = m[3]; m[3] = tm;
        end
        if (t[3] < t[2]) begin
          tt = t[2]; t[2] = t[3]; t[3] = tt;
          tm = m[2]; m[2] = m[3]; m[3] = tm;
        end
      end
      default: begin
      end
    endcase
  end

  // pack the classified item
  always_comb begin
    item_d.kind    = s_user_i;
    item_d.tuple.a = t[0];
    item_d.tuple.b = t[1];
    item_d.tuple.c = t[2];
    item_d.tuple.d = t[3];
    item_d.atoms.a = m[0];
    item_d.atoms.b = m[1];
    item_d.atoms.c = m[2];
    item_d.atoms.d = m[3];
  end

  // output stage handshake
  assign s_ready_o = !vld_q || item_ready_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (item_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

[hdl/ctc_fifo.sv]
// short queue of classified items between front and back end
// depends on ctc_pkg for the item type and the queue depth
module ctc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  ctc_pkg::ctc_item_t wr_item_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output ctc_pkg::ctc_item_t rd_item_o
);
  import ctc_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  ctc_item_t       slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            push, pop;

  assign wr_ready_o = cnt_q != Full;
  assign rd_valid_o = cnt_q != '0;
  assign rd_item_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

[hdl/ctc_back.sv]
// back end: per-kind table search and append, one entry compared per cycle
// depends on ctc_pkg; holds the tuple memory, the entry counts and the result register
module ctc_back #(
  parameter int unsigned TABLE_DEPTH = ctc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  ctc_pkg::ctc_item_t   q_item_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output ctc_pkg::ctc_result_t res_o
);
  import ctc_pkg::*;

  localparam int unsigned IdxW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned MemDepth = KIND_COUNT * TABLE_DEPTH;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam logic [AddrW-1:0] DepthA    = AddrW'(TABLE_DEPTH);
  localparam logic [IdxW-1:0]  FullCount = IdxW'(TABLE_DEPTH - 1);

  ctc_state_e       state_d, state_q;
  logic [IdxW-1:0]  cnt_q [KIND_COUNT];
  ctc_tuple_t       mem_q [MemDepth];
  ctc_tuple_t       rdata_q;
  logic [2:0]       kind_q;
  ctc_tuple_t       tuple_q;
  ctc_atoms_t       atoms_q;
  logic [IdxW-1:0]  n_q, n_in;
  logic [IdxW-1:0]  rd_idx_q, cmp_idx_q;
  logic             cmp_vld_q;
  logic [IdxW-1:0]  res_idx_q;
  logic             res_new_q, res_ovf_q;
  ctc_result_t      out_q;
  logic             out_vld_q;
  logic             pop, issue, hit, miss, full, mem_we, out_free;
  logic [AddrW-1:0] base, raddr, waddr;

  // count of the incoming kind; zero for clear and unknown kinds
  always_comb begin
    n_in = '0;
    for (int k = 0; k < KIND_COUNT; k++) begin
      if (q_item_i.kind == 3'(k)) begin
        n_in = cnt_q[k];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_item_i.kind < 3'(KIND_COUNT)) ? ST_SEARCH : ST_RESP;
        end
      end
      ST_SEARCH: begin
        if (hit || miss) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_ready_o = state_q == ST_IDLE;
    pop       = q_valid_i && q_ready_o;
    issue     = (state_q == ST_SEARCH) && (rd_idx_q != n_q);
    hit       = (state_q == ST_SEARCH) && cmp_vld_q && (rdata_q == tuple_q);
    miss      = (state_q == ST_SEARCH) && !hit && (rd_idx_q == n_q);
    full      = n_q >= FullCount;
    mem_we    = miss && !full;
    out_free  = !out_vld_q || res_ready_i;
    base      = AddrW'(kind_q) * DepthA;
    raddr     = base + AddrW'(rd_idx_q);
    waddr     = base + AddrW'(n_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < KIND_COUNT; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= issue;
      if (state_q == ST_RESP && out_free) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
      // clear empties every table, an append bumps its own count
      if (pop && q_item_i.kind == KIND_CLEAR) begin
        for (int k = 0; k < KIND_COUNT; k++) begin
          cnt_q[k] <= '0;
        end
      end else if (mem_we) begin
        for (int k = 0; k < KIND_COUNT; k++) begin
          if (kind_q == 3'(k)) begin
            cnt_q[k] <= n_q + 1'b1;
          end
        end
      end
    end
  end

  // item, scan and result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      kind_q    <= q_item_i.kind;
      tuple_q   <= q_item_i.tuple;
      atoms_q   <= q_item_i.atoms;
      n_q       <= n_in;
      rd_idx_q  <= '0;
      res_idx_q <= '0;
      res_new_q <= 1'b0;
      res_ovf_q <= 1'b0;
    end
    if (issue) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end
    cmp_idx_q <= rd_idx_q;
    if (hit) begin
      res_idx_q <= cmp_idx_q;
    end else if (miss) begin
      res_idx_q <= full ? '0 : n_q;
      res_new_q <= !full;
      res_ovf_q <= full;
    end
    if (state_q == ST_RESP && out_free) begin
      out_q.type_index <= INDEX_W'(res_idx_q);
      out_q.ordered    <= atoms_q;
      out_q.new_entry  <= res_new_q;
      out_q.overflow   <= res_ovf_q;
    end
  end

  // tuple memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= tuple_q;
    end
    if (issue) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

[hdl/canonical_tuple_type_classifier.sv]
// canonical tuple type classifier: a search item holds the back end while its scan of the tuple memory,
// one entry per cycle, runs over the n entries stored for its kind (up to TABLE_DEPTH - 1);
// a hit at entry k ends the scan there, and clear and unknown kinds skip the scan;
// reset zeroes all entry counts and empties queue and result register at once;
// table memory has no clearing pass, stale entries are never read
module canonical_tuple_type_classifier #(
  parameter int unsigned TABLE_DEPTH = ctc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // type_a, type_b, type_c, type_d, atom_a, atom_b, atom_c, atom_d, zero fill
  input  logic [ctc_pkg::S_DATA_W-1:0] s_axis_tdata,
  // kind
  input  logic [ctc_pkg::S_USER_W-1:0] s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // type_index, ordered_a, ordered_b, ordered_c, ordered_d, zero fill
  output logic [ctc_pkg::M_DATA_W-1:0] m_axis_tdata,
  // new_entry, overflow
  output logic [ctc_pkg::M_USER_W-1:0] m_axis_tuser
);
  import ctc_pkg::*;

  ctc_item_t   f_item, q_item;
  logic        f_valid, f_ready, q_valid, q_ready;
  ctc_result_t res;

  // classify and reorder
  ctc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  // decoupling queue
  ctc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_item_i  (f_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  // table search and append
  ctc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // result packing
  assign m_axis_tdata = {(M_DATA_W - INDEX_W - 4 * ATOM_W)'(0), res.ordered, res.type_index};
  assign m_axis_tuser = {res.overflow, res.new_entry};

endmodule
